// ----- sv/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, constants and helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 8;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} res_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF) ||
			(c >= CH_LA && c <= CH_LF);
	endfunction

	// valid only for hex digit characters
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return (c <= CH_NINE) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

endpackage

// ----- sv/url_percent_decoder.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder
// Decodes a URL-encoded byte stream: %XX escapes and '+' as space.
// ----------------------------------------------------------------------------
// A result passes the input stage register and the result queue to m_axis.
// Throughput: one input byte per cycle while the queue has room; one output
// byte per cycle while m_axis_tready is high, set by the single read port of
// the queue. Input stalls while the queue has fewer than three free entries.
// Reset clears the input stage, escape state and queue pointers.
module url_percent_decoder #(
	parameter int FIFO_DEPTH = upd_pkg::FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PCT  = 3'b010,
		PH_DIG  = 3'b100
	} phase_t;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	phase_t        phase_q;
	logic [7:0]    held_q;

	phase_t        nph;
	logic [7:0]    nheld;
	logic [1:0]    n;
	logic          do_plain;
	upd_pkg::res_t res [upd_pkg::MAX_RES];

	logic          room;
	logic          proc;
	logic          pop;
	upd_pkg::res_t head;

	assign proc          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || proc;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (proc) begin
			phase_q <= nph;
			held_q  <= nheld;
		end
	end

	always_comb begin
		nph      = phase_q;
		nheld    = held_q;
		n        = 2'd0;
		do_plain = 1'b0;
		for (int i = 0; i < upd_pkg::MAX_RES; i++) begin
			res[i] = '0;
		end
		unique case (phase_q)
			PH_PCT: begin
				if (upd_pkg::is_hex(byte_s1)) begin
					nph   = PH_DIG;
					nheld = byte_s1;
				end else begin
					res[n].data = upd_pkg::CH_PCT;
					n           = n + 2'd1;
					do_plain    = 1'b1;
				end
			end
			PH_DIG: begin
				if (upd_pkg::is_hex(byte_s1)) begin
					nph         = PH_IDLE;
					res[n].data = {upd_pkg::hex_val(held_q), upd_pkg::hex_val(byte_s1)};
					n           = n + 2'd1;
				end else begin
					res[n].data = upd_pkg::CH_PCT;
					n           = n + 2'd1;
					res[n].data = held_q;
					n           = n + 2'd1;
					do_plain    = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase
		if (do_plain) begin
			nph = PH_IDLE;
			if (byte_s1 == upd_pkg::CH_PCT) begin
				nph = PH_PCT;
			end else begin
				res[n].data = (byte_s1 == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : byte_s1;
				n           = n + 2'd1;
			end
		end
		if (last_s1) begin
			if (nph == PH_PCT) begin
				res[n].data = upd_pkg::CH_PCT;
				n           = n + 2'd1;
			end else if (nph == PH_DIG) begin
				res[n].data = upd_pkg::CH_PCT;
				n           = n + 2'd1;
				res[n].data = nheld;
				n           = n + 2'd1;
			end
			nph   = PH_IDLE;
			nheld = '0;
			if (n != 2'd0) begin
				res[n - 2'd1].last = 1'b1;
			end
		end
	end

	upd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_n      (proc ? n : 2'd0),
		.wr_data   (res),
		.pop       (pop),
		.head      (head),
		.not_empty (m_axis_tvalid),
		.room      (room)
	);

	assign m_axis_tdata = head.data;
	assign m_axis_tlast = head.last;

`ifndef SYNTH
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> phase_q == PH_IDLE && held_q == '0)
		else $error("escape state not cleared after end of string");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |-> n != 2'd0)
		else $error("final byte produced no result");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && !room)
		else $error("input stalled without a blocked item");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		proc && phase_q == PH_PCT && upd_pkg::is_hex(byte_s1) && !last_s1 |-> n == 2'd0)
		else $error("result emitted while escape still pending");
`endif

endmodule

// ----- sv/upd_fifo.sv -----
// ----------------------------------------------------------------------------
// upd_fifo
// Result queue: takes up to three words per cycle, gives one per cycle on pop.
// ----------------------------------------------------------------------------
module upd_fifo #(
	parameter int DEPTH = upd_pkg::FIFO_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      wr_n,
	input  upd_pkg::res_t   wr_data [upd_pkg::MAX_RES],
	input  logic            pop,
	output upd_pkg::res_t   head,
	output logic            not_empty,
	output logic            room
);

	localparam int AW = $clog2(DEPTH);

	upd_pkg::res_t  mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < upd_pkg::MAX_RES; i++) begin
			if (2'(i) < wr_n) begin
				mem_q[wr_ptr_q + AW'(i)] <= wr_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(wr_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(wr_n) - (AW+1)'(pop);
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign room      = (cnt_q <= (AW+1)'(DEPTH - upd_pkg::MAX_RES));

endmodule
